[design/kvd_pkg.sv]
// Package for the key velocity detector: widths, register indexes, reset values,
// phase codes and the command/status structs between controller and datapath.
// No dependencies.
package kvd_pkg;

  // Field widths
  localparam int unsigned LevelW = 16;
  localparam int unsigned SumW   = LevelW + 1;
  localparam int unsigned DurW   = 32;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned IdxW   = 8;

  // Velocity divider: one quotient bit per step
  localparam int unsigned DivSteps = LevelW;
  localparam int unsigned StepW    = $clog2(DivSteps);

  // Register indexes on the configuration port
  localparam logic [IdxW-1:0] RegThHigh  = IdxW'(0);
  localparam logic [IdxW-1:0] RegThLow   = IdxW'(1);
  localparam logic [IdxW-1:0] RegRelease = IdxW'(2);
  localparam logic [IdxW-1:0] RegVelNum  = IdxW'(3);

  // Register reset values (full scale 65535 = 1.0)
  localparam logic [LevelW-1:0] ThHighRst  = LevelW'(26214);
  localparam logic [LevelW-1:0] ThLowRst   = LevelW'(11796);
  localparam logic [LevelW-1:0] ReleaseRst = LevelW'(27525);
  localparam logic [LevelW-1:0] VelNumRst  = LevelW'(14300);

  // Key phase codes
  localparam logic [PhaseW-1:0] PhaseIdle    = 2'd0;
  localparam logic [PhaseW-1:0] PhaseAttack  = 2'd1;
  localparam logic [PhaseW-1:0] PhaseSustain = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic take;  // input transfer: update key state, load divider
    logic step;  // one divider iteration
    logic last;  // final divider iteration, write velocity
    logic emit;  // load output register
  } kvd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic onset;     // current input frame enters sustain
    logic out_free;  // output register can take a result
  } kvd_sts_t;

endpackage

[design/kvd_if.sv]
// Channel interfaces of the key velocity detector: sensor frame input, result
// output and configuration write. Depends on kvd_pkg.
interface kvd_in_if;
  import kvd_pkg::*;
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] reading_first;
  logic [LevelW-1:0] reading_second;
  modport source (output valid, output reading_first, output reading_second, input ready);
  modport sink   (input valid, input reading_first, input reading_second, output ready);
endinterface

interface kvd_out_if;
  import kvd_pkg::*;
  logic              valid;
  logic              ready;
  logic [PhaseW-1:0] key_phase;
  logic              onset;
  logic [LevelW-1:0] velocity;
  logic [LevelW-1:0] press_count;
  logic [DurW-1:0]   duration_frames;
  modport source (output valid, output key_phase, output onset, output velocity,
                  output press_count, output duration_frames, input ready);
  modport sink   (input valid, input key_phase, input onset, input velocity,
                  input press_count, input duration_frames, output ready);
endinterface

interface kvd_cfg_if;
  import kvd_pkg::*;
  logic              valid;
  logic              ready;
  logic [IdxW-1:0]   index;
  logic [LevelW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[design/key_velocity_detector_unit.sv]
// Top level of the two-threshold key velocity detector.
// Depends on kvd_pkg, kvd_if, kvd_ctrl and kvd_datapath.
//
// Each input transfer is one sensor frame; each frame yields exactly one result.
// A frame that does not complete an attack is accepted and evaluated in the accept
// cycle, then handed to the output register from the pending state once it is free.
// A frame that completes an attack also runs the velocity quotient through a
// restoring divider that produces one quotient bit per cycle before the pending
// state is entered. The output register holds a finished result while the
// next frame is taken and evaluated; a result waits only if the previous one
// has not yet been transferred out. Configuration writes are always accepted
// and must only be issued while no frame is in flight.
module key_velocity_detector_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  kvd_in_if.sink    in_i,
  kvd_cfg_if.sink   cfg_i,
  kvd_out_if.source out_o
);
  import kvd_pkg::*;

  kvd_cmd_t cmd;
  kvd_sts_t sts;
  logic     in_ready;

  assign in_i.ready = in_ready;

  kvd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kvd_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .out_o  (out_o)
  );

endmodule

[design/kvd_ctrl.sv]
// Controller of the key velocity detector: input handshake, divider sequencing
// and output hand-off. Depends on kvd_pkg.
module kvd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  kvd_pkg::kvd_sts_t sts_i,
  output kvd_pkg::kvd_cmd_t cmd_o
);
  import kvd_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StPend = 2'd2;

  logic [1:0]       st_q, st_d;
  logic [StepW-1:0] cnt_q, cnt_d;

  assign in_ready_o = (st_q == StIdle);

  // Next state and commands
  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    cmd_o = '0;
    unique case (st_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          cnt_d      = '0;
          st_d       = sts_i.onset ? StDiv : StPend;
        end
      end
      StDiv: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == StepW'(DivSteps - 1)) begin
          cmd_o.last = 1'b1;
          st_d       = StPend;
        end
      end
      StPend: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          st_d       = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  // An onset frame always runs the divider
  a_onset_divides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && sts_i.onset) |=> (st_q == StDiv && cnt_q == '0))
    else $error("onset frame did not start the divider");

  // Divider ends after its last step
  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StDiv && cnt_q == StepW'(DivSteps - 1)) |=> (st_q == StPend))
    else $error("divider overran its step count");

  // Result is handed off only into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (st_q == StPend && sts_i.out_free))
    else $error("result loaded into a busy output register");

endmodule

[design/kvd_datapath.sv]
// Datapath of the key velocity detector: configuration registers, key phase and
// run length, serial velocity divider and output register. Depends on kvd_pkg, kvd_if.
module kvd_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kvd_pkg::kvd_cmd_t cmd_i,
  output kvd_pkg::kvd_sts_t sts_o,
  kvd_in_if.sink            in_i,
  kvd_cfg_if.sink           cfg_i,
  kvd_out_if.source         out_o
);
  import kvd_pkg::*;

  // Configuration
  logic [LevelW-1:0] th_high_q, th_low_q, release_q, vel_num_q;
  // Key state
  logic [PhaseW-1:0] phase_q;
  logic [DurW-1:0]   dur_q;
  logic [LevelW-1:0] presses_q;
  logic [LevelW-1:0] vel_q;
  logic              onset_q;
  // Divider
  logic [LevelW-1:0] quo_q, quo_d;
  logic [LevelW-1:0] rem_q, rem_d;
  logic [DurW-1:0]   dvs_q;
  // Output register
  logic              out_vld_q;
  logic [PhaseW-1:0] out_phase_q;
  logic              out_onset_q;
  logic [LevelW-1:0] out_vel_q;
  logic [LevelW-1:0] out_press_q;
  logic [DurW-1:0]   out_dur_q;

  logic [SumW-1:0]   sum;
  logic [DurW-1:0]   run;
  logic [DurW-1:0]   len;
  logic [PhaseW-1:0] phase_nx;
  logic              hit;
  logic [SumW-1:0]   rem_sh;
  logic              ge;

  // Config writes, always ready; unknown indexes dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      th_high_q <= ThHighRst;
      th_low_q  <= ThLowRst;
      release_q <= ReleaseRst;
      vel_num_q <= VelNumRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegThHigh:  th_high_q <= cfg_i.data;
        RegThLow:   th_low_q  <= cfg_i.data;
        RegRelease: release_q <= cfg_i.data;
        RegVelNum:  vel_num_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Frame evaluation: sum of both readings against doubled thresholds
  assign sum = {1'b0, in_i.reading_first} + {1'b0, in_i.reading_second};

  always_comb begin
    run = dur_q;
    if (phase_q != PhaseIdle) begin
      run = (&dur_q) ? dur_q : dur_q + DurW'(1);
    end
    phase_nx = phase_q;
    hit      = 1'b0;
    // checks run in order, so one frame may pass several phases
    if (sum < {th_high_q, 1'b0} && phase_nx == PhaseIdle) begin
      phase_nx = PhaseAttack;
      run      = '0;
    end
    if (sum < {th_low_q, 1'b0} && phase_nx == PhaseAttack) begin
      phase_nx = PhaseSustain;
      hit      = 1'b1;
    end
    if (sum > {release_q, 1'b0} && phase_nx == PhaseSustain) begin
      phase_nx = PhaseIdle;
    end
    // attack entered and finished in one frame counts as one frame
    len = (run == '0) ? DurW'(1) : run;
  end

  assign sts_o.onset    = hit;
  assign sts_o.out_free = !out_vld_q || out_o.ready;

  // Restoring divider step: remainder never exceeds the dividend width
  assign rem_sh = {rem_q, quo_q[LevelW-1]};
  assign ge     = {{(DurW - SumW){1'b0}}, rem_sh} >= dvs_q;
  always_comb begin
    rem_d = ge ? LevelW'(rem_sh - dvs_q[SumW-1:0]) : rem_sh[LevelW-1:0];
    quo_d = {quo_q[LevelW-2:0], ge};
  end

  // Key state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhaseIdle;
      dur_q     <= '0;
      presses_q <= '0;
      vel_q     <= '0;
      onset_q   <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        phase_q <= phase_nx;
        onset_q <= hit;
        if (phase_nx != PhaseIdle) begin
          dur_q <= run;
        end
        if (hit) begin
          presses_q <= presses_q + 1'b1;
        end
      end
      if (cmd_i.last) begin
        vel_q <= quo_d;
      end
    end
  end

  // Divider registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      quo_q <= vel_num_q;
      rem_q <= '0;
      dvs_q <= len;
    end else if (cmd_i.step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_phase_q <= phase_q;
      out_onset_q <= onset_q;
      out_vel_q   <= vel_q;
      out_press_q <= presses_q;
      out_dur_q   <= dur_q;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.key_phase       = out_phase_q;
  assign out_o.onset           = out_onset_q;
  assign out_o.velocity        = out_vel_q;
  assign out_o.press_count     = out_press_q;
  assign out_o.duration_frames = out_dur_q;

  // Each onset bumps the press count by exactly one
  a_press_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.take && hit) |=> (presses_q == LevelW'($past(presses_q) + 1'b1)))
    else $error("press count not advanced on onset");

  // Key state is frozen while the divider runs
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> (phase_q == $past(phase_q) && dur_q == $past(dur_q)))
    else $error("key state changed during division");

endmodule

[sim/tb.sv]
// Testbench for key_velocity_detector_unit: drives sensor frames and register writes,
// predicts every frame result in a scoreboard class and compares them field by field.
// Depends on kvd_pkg, kvd_if and the RTL of the detector.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kvd_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam int unsigned RandomFrames = 500;
  localparam int unsigned MaxGap = 14;
  localparam int unsigned SettleCycles = 24;
  localparam int SumMax = 131070;
  localparam logic [IdxW-1:0] RegUnused = IdxW'(4);
  localparam logic [IdxW-1:0] RegTop = '1;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              onset;
    logic [LevelW-1:0] velocity;
    logic [LevelW-1:0] presses;
    logic [DurW-1:0]   duration;
  } key_result_t;

  // Key state tracker and expected result store
  class key_frame_scoreboard;
    logic [LevelW-1:0] th_high, th_low, th_release, vel_num;
    logic [PhaseW-1:0] phase;
    logic [LevelW-1:0] velocity, presses;
    logic [DurW-1:0]   run_len;
    key_result_t       expected_q[$];
    int unsigned       failures;
    int unsigned       reported;

    function new();
      th_high    = ThHighRst;
      th_low     = ThLowRst;
      th_release = ReleaseRst;
      vel_num    = VelNumRst;
      phase      = PhaseIdle;
      velocity   = '0;
      presses    = '0;
      run_len    = '0;
      failures   = 0;
      reported   = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [IdxW-1:0] idx, logic [LevelW-1:0] value);
      case (idx)
        RegThHigh:  th_high = value;
        RegThLow:   th_low = value;
        RegRelease: th_release = value;
        RegVelNum:  vel_num = value;
        default: ;  // unknown index is dropped
      endcase
    endfunction

    // One frame transfer: evaluate attack, sustain and release in that order
    function void note_frame(logic [LevelW-1:0] first, logic [LevelW-1:0] second);
      logic [SumW-1:0] level_sum;
      logic [DurW-1:0] run, span;
      key_result_t     res;
      level_sum = SumW'(first) + SumW'(second);
      if (phase == PhaseIdle) run = run_len;
      else run = (run_len == '1) ? run_len : run_len + 1;
      res.onset = 1'b0;
      if (phase == PhaseIdle && level_sum < {th_high, 1'b0}) begin
        phase = PhaseAttack;
        run = '0;
      end
      if (phase == PhaseAttack && level_sum < {th_low, 1'b0}) begin
        // attack begun this same frame counts as one frame long
        span = (run == '0) ? DurW'(1) : run;
        phase = PhaseSustain;
        velocity = LevelW'(DurW'(vel_num) / span);
        presses = presses + 1'b1;
        res.onset = 1'b1;
      end
      if (phase == PhaseSustain && level_sum > {th_release, 1'b0}) phase = PhaseIdle;
      if (phase != PhaseIdle) run_len = run;
      res.phase = phase;
      res.velocity = velocity;
      res.presses = presses;
      res.duration = run_len;
      expected_q.push_back(res);
    endfunction

    function void check_result(key_result_t got);
      key_result_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (reported < 10)
          $display("unexpected result transfer: phase=%0d onset=%0d vel=%0d presses=%0d dur=%0d",
                   got.phase, got.onset, got.velocity, got.presses, got.duration);
        reported++;
        return;
      end
      want = expected_q.pop_front();
      if (got.phase !== want.phase || got.onset !== want.onset ||
          got.velocity !== want.velocity || got.presses !== want.presses ||
          got.duration !== want.duration) begin
        failures++;
        if (reported < 10)
          $display("frame result mismatch at %0t: expected phase=%0d onset=%0d vel=%0d presses=%0d dur=%0d, got phase=%0d onset=%0d vel=%0d presses=%0d dur=%0d",
                   $realtime, want.phase, want.onset, want.velocity, want.presses,
                   want.duration, got.phase, got.onset, got.velocity, got.presses,
                   got.duration);
        reported++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  kvd_in_if  in_if ();
  kvd_cfg_if cfg_if ();
  kvd_out_if out_if ();

  key_velocity_detector_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  key_frame_scoreboard frames_sb = new();
  int unsigned frames_sent = 0;
  bit          no_gaps = 1'b0;
  int unsigned cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Run limit
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random stall per result, then wait for the transfer
  initial begin : result_sink
    int unsigned stall;
    key_result_t got;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(MaxGap, 0);
      @(negedge clk_i);
      if (stall != 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      got.phase    = out_if.key_phase;
      got.onset    = out_if.onset;
      got.velocity = out_if.velocity;
      got.presses  = out_if.press_count;
      got.duration = out_if.duration_frames;
      frames_sb.check_result(got);
    end
  end

  // One frame transfer; valid stays high when the next frame has no gap
  task automatic send_frame(input logic [LevelW-1:0] first, input logic [LevelW-1:0] second);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(MaxGap, 0);
    @(negedge clk_i);
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.reading_first = first;
    in_if.reading_second = second;
    do @(posedge clk_i); while (!in_if.ready);
    frames_sb.note_frame(first, second);
    frames_sent++;
  endtask

  // Frame whose reading sum falls in [lo, hi]; an empty range gives any sum
  task automatic send_level(input int lo, input int hi);
    int s, r1;
    if (lo > hi) s = $urandom_range(SumMax, 0);
    else s = $urandom_range(hi, lo);
    r1 = $urandom_range((s > 65535) ? 65535 : s, (s > 65535) ? s - 65535 : 0);
    send_frame(LevelW'(r1), LevelW'(s - r1));
  endtask

  // Stop sending and wait until every frame result is out
  task automatic settle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (frames_sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [LevelW-1:0] value);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data = value;
    do @(posedge clk_i); while (!cfg_if.ready);
    frames_sb.write_reg(idx, value);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic apply_config(input int th, input int tl, input int rel, input int num);
    settle();
    write_reg(RegThHigh, LevelW'(th));
    write_reg(RegThLow, LevelW'(tl));
    write_reg(RegRelease, LevelW'(rel));
    write_reg(RegVelNum, LevelW'(num));
    // unknown index must leave the registers alone
    write_reg(($urandom_range(1, 0) == 0) ? RegUnused : RegTop, LevelW'($urandom));
  endtask

  // Idle, attack, sustain, release; broken presses end in random frames after the attack
  task automatic key_press(input bit broken);
    int hi2, lo2, rel2, n;
    hi2 = 2 * int'(frames_sb.th_high);
    lo2 = 2 * int'(frames_sb.th_low);
    rel2 = 2 * int'(frames_sb.th_release);
    repeat ($urandom_range(3, 0)) send_level(hi2, SumMax);
    n = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 0);
    repeat (n) send_level(lo2, hi2 - 1);
    if (broken) begin
      repeat ($urandom_range(4, 1)) send_level(0, SumMax);
      return;
    end
    send_level(0, lo2 - 1);
    repeat ($urandom_range(5, 0)) send_level(0, rel2);
    send_level(rel2 + 1, SumMax);
  endtask

  initial begin : stimulus
    int unsigned phase_no, quota, phase_end, pick, random_end;
    int th, tl, rel;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.reading_first = '0;
    in_if.reading_second = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed frames at reset thresholds
    send_frame(16'hFFFF, 16'hFFFF);   // full scale, stays idle
    send_frame(16'd30000, 16'd30000);
    send_frame(16'd26213, 16'd26214); // one below twice the high threshold
    send_frame(16'd20000, 16'd20000);
    send_frame(16'd11796, 16'd11796); // exactly at low threshold, still attack
    send_frame(16'd11795, 16'd11796); // onset after a multi-frame attack
    send_frame(16'd27525, 16'd27525); // exactly at release, holds sustain
    send_frame(16'd27525, 16'd27526); // back to idle
    send_frame(16'd0, 16'd0);         // idle straight to sustain, zero attack length
    send_frame(16'hFFFF, 16'd0);
    send_frame(16'd0, 16'hFFFF);

    // Thresholds that let one frame go idle -> attack -> sustain -> idle
    apply_config(65535, 65535, 0, 0);
    send_frame(16'd1, 16'd0);
    apply_config(65535, 65535, 0, 65535);
    send_frame(16'd0, 16'd0);         // sum zero is not above release, stays sustain
    send_frame(16'hFFFF, 16'hFFFE);
    send_frame(16'hFFFF, 16'hFFFF);   // top sum is not below the top threshold
    apply_config(0, 0, 65535, 1);
    send_frame(16'd0, 16'd0);         // nothing can start an attack
    send_frame(16'hFFFF, 16'hFFFF);

    // Random phases with well-formed presses, broken presses and noise
    random_end = frames_sent + RandomFrames;
    phase_no = 0;
    while (frames_sent < random_end) begin
      phase_no++;
      if (phase_no % 4 == 0) begin
        case ((phase_no / 4) % 4)
          0: apply_config(65535, 65535, 0, $urandom_range(65535, 0));
          1: apply_config(0, 0, 65535, 0);
          2: apply_config(65535, 0, 65535, 65535);  // attack that never completes
          default: apply_config(65535, 65535, 65535, 1);
        endcase
        quota = 20;
      end else begin
        tl = $urandom_range(30000, 0);
        th = tl + $urandom_range(25000, 1);
        rel = th + $urandom_range(12000, 0);
        if (rel > 65535) rel = 65535;
        apply_config(th, tl, rel, $urandom_range(65535, 0));
        quota = 50;
      end
      no_gaps = ($urandom_range(3, 0) == 0);
      phase_end = frames_sent + quota;
      while (frames_sent < phase_end) begin
        pick = $urandom_range(9, 0);
        if (pick == 0) send_frame(LevelW'($urandom), LevelW'($urandom));
        else key_press(pick == 1);
      end
    end

    settle();
    if (frames_sb.failures == 0 && frames_sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
